// ===== rtl/radial_deadzone_rescale_unit_defines.svh =====
// ----------------------------------------------------------------------------
// radial deadzone rescale unit: assertion macros
// shared property forms for the checks at the end of the top-level one of the rtl modules
// ----------------------------------------------------------------------------
`ifndef RADIAL_DEADZONE_RESCALE_UNIT_DEFINES_SVH
`define RADIAL_DEADZONE_RESCALE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RDZ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rdz assertion failed");

// next-cycle implication, checked out of reset
`define RDZ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdz assertion failed");

`endif

// ===== rtl/rdz_pkg.sv =====
// ----------------------------------------------------------------------------
// rdz_pkg
// beat types and fixed widths of the radial deadzone rescale unit
// ----------------------------------------------------------------------------
package rdz_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RADIUS_W = 14;
    localparam int SQ_W     = 32;
    localparam int MAG_W    = 16;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 14'd2458;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] stick_x;
        logic signed [SAMPLE_W-1:0] stick_y;
    } stick_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_x;
        logic signed [SAMPLE_W-1:0] out_y;
    } result_t;

    // axis magnitudes, signs and the force-to-zero flag
    typedef struct packed {
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        logic             sx;
        logic             sy;
        logic             zero;
    } axes_t;

endpackage

// ===== rtl/rdz_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// rdz_sqrt_pipe
// integer square root, one result bit per pipeline stage, with sideband
// ----------------------------------------------------------------------------
module rdz_sqrt_pipe (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      sq_valid,
    input  logic [rdz_pkg::SQ_W-1:0]  sq,
    input  rdz_pkg::axes_t            sq_side,
    output logic                      root_valid,
    output logic [rdz_pkg::MAG_W-1:0] root,
    output rdz_pkg::axes_t            root_side
);
    import rdz_pkg::*;

    localparam int STEPS = MAG_W;
    localparam int REM_W = MAG_W + 1;
    localparam int TRY_W = MAG_W + 3;

    logic             v_q    [STEPS];
    logic [SQ_W-1:0]  s_q    [STEPS];
    logic [REM_W-1:0] rem_q  [STEPS];
    logic [MAG_W-1:0] root_q [STEPS];
    axes_t            side_q [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic             v_in;
        logic [SQ_W-1:0]  s_in;
        logic [REM_W-1:0] rem_in;
        logic [MAG_W-1:0] root_in;
        axes_t            side_in;
        logic [TRY_W-1:0] shifted;
        logic [TRY_W-1:0] trial;
        logic             ge;
        logic [REM_W-1:0] rem_next;
        logic [MAG_W-1:0] root_next;
        logic             v_reg;
        logic [SQ_W-1:0]  s_reg;
        logic [REM_W-1:0] rem_reg;
        logic [MAG_W-1:0] root_reg;
        axes_t            side_reg;

        if (k == 0)
        begin : g_first
            assign v_in    = sq_valid;
            assign s_in    = sq;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = sq_side;
        end
        else
        begin : g_rest
            assign v_in    = v_q[k-1];
            assign s_in    = s_q[k-1];
            assign rem_in  = rem_q[k-1];
            assign root_in = root_q[k-1];
            assign side_in = side_q[k-1];
        end

        always_comb
        begin
            shifted   = {rem_in, s_in[2*(STEPS-1-k) +: 2]};
            trial     = {1'b0, root_in, 2'b01};
            ge        = (shifted >= trial);
            rem_next  = ge ? REM_W'(shifted - trial) : REM_W'(shifted);
            root_next = {root_in[MAG_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg    <= s_in;
                rem_reg  <= rem_next;
                root_reg <= root_next;
                side_reg <= side_in;
            end
        end

        assign v_q[k]    = v_reg;
        assign s_q[k]    = s_reg;
        assign rem_q[k]  = rem_reg;
        assign root_q[k] = root_reg;
        assign side_q[k] = side_reg;
    end

    assign root_valid = v_q[STEPS-1];
    assign root       = root_q[STEPS-1];
    assign root_side  = side_q[STEPS-1];

endmodule

// ===== rtl/rdz_div_pipe.sv =====
// ----------------------------------------------------------------------------
// rdz_div_pipe
// restoring divider, one quotient bit per stage, lanes sharing one divisor
// ----------------------------------------------------------------------------
module rdz_div_pipe #(
    parameter int LANES  = 1,
    parameter int STEPS  = 14,
    parameter int DEN_W  = 15,
    parameter int SIDE_W = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              num_valid,
    input  logic [LANES-1:0][DEN_W-1:0]       num_rem,
    input  logic [LANES-1:0][STEPS-1:0]       num_low,
    input  logic [DEN_W-1:0]                  den,
    input  logic [SIDE_W-1:0]                 num_side,
    output logic                              quot_valid,
    output logic [LANES-1:0][STEPS-1:0]       quot,
    output logic [SIDE_W-1:0]                 quot_side
);
    logic                        v_q    [STEPS];
    logic [LANES-1:0][DEN_W-1:0] rem_q  [STEPS];
    logic [LANES-1:0][STEPS-1:0] low_q  [STEPS];
    logic [LANES-1:0][STEPS-1:0] q_q    [STEPS];
    logic [DEN_W-1:0]            den_q  [STEPS];
    logic [SIDE_W-1:0]           side_q [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic                        v_in;
        logic [LANES-1:0][DEN_W-1:0] rem_in;
        logic [LANES-1:0][STEPS-1:0] low_in;
        logic [LANES-1:0][STEPS-1:0] q_in;
        logic [DEN_W-1:0]            den_in;
        logic [SIDE_W-1:0]           side_in;
        logic [LANES-1:0][DEN_W-1:0] rem_next;
        logic [LANES-1:0][STEPS-1:0] q_next;
        logic                        v_reg;
        logic [LANES-1:0][DEN_W-1:0] rem_reg;
        logic [LANES-1:0][STEPS-1:0] low_reg;
        logic [LANES-1:0][STEPS-1:0] q_reg;
        logic [DEN_W-1:0]            den_reg;
        logic [SIDE_W-1:0]           side_reg;

        if (k == 0)
        begin : g_first
            assign v_in    = num_valid;
            assign rem_in  = num_rem;
            assign low_in  = num_low;
            assign q_in    = '0;
            assign den_in  = den;
            assign side_in = num_side;
        end
        else
        begin : g_rest
            assign v_in    = v_q[k-1];
            assign rem_in  = rem_q[k-1];
            assign low_in  = low_q[k-1];
            assign q_in    = q_q[k-1];
            assign den_in  = den_q[k-1];
            assign side_in = side_q[k-1];
        end

        always_comb
        begin
            logic [DEN_W:0] shifted;
            logic           ge;
            for (int l = 0; l < LANES; l++)
            begin
                shifted     = {rem_in[l], low_in[l][STEPS-1-k]};
                ge          = (shifted >= {1'b0, den_in});
                rem_next[l] = ge ? DEN_W'(shifted - {1'b0, den_in}) : DEN_W'(shifted);
                q_next[l]   = {q_in[l][STEPS-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                low_reg  <= low_in;
                q_reg    <= q_next;
                den_reg  <= den_in;
                side_reg <= side_in;
            end
        end

        assign v_q[k]    = v_reg;
        assign rem_q[k]  = rem_reg;
        assign low_q[k]  = low_reg;
        assign q_q[k]    = q_reg;
        assign den_q[k]  = den_reg;
        assign side_q[k] = side_reg;
    end

    assign quot_valid = v_q[STEPS-1];
    assign quot       = q_q[STEPS-1];
    assign quot_side  = side_q[STEPS-1];

endmodule

// ===== rtl/radial_deadzone_rescale_unit.sv =====
// throughput: one sample per cycle; every stage moves each cycle unless the skid stage is full
// depth is set by the 16-stage square root, the FRAC_BITS-stage remap divider
// and the (FRAC_BITS+1)-stage axis dividers
// reset: rst_n clears all valid bits and loads the radius register with 2458
// ----------------------------------------------------------------------------
// radial_deadzone_rescale_unit
// scaled radial deadzone for one two-axis stick sample in signed fixed point
// ----------------------------------------------------------------------------
`include "radial_deadzone_rescale_unit_defines.svh"

module radial_deadzone_rescale_unit #(
    parameter int FRAC_BITS = 14
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         stick_valid,
    output logic                         stick_ready,
    input  rdz_pkg::stick_t              stick,
    output logic                         result_valid,
    input  logic                         result_ready,
    output rdz_pkg::result_t             result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rdz_pkg::RADIUS_W-1:0] cfg_data
);
    import rdz_pkg::*;

    localparam int ONE_W = FRAC_BITS + 1;
    localparam int QW    = ONE_W;
    localparam int PW    = MAG_W + ONE_W;
    localparam int RSQ_W = 2 * RADIUS_W;
    localparam int CMP_W = (ONE_W > MAG_W) ? ONE_W : MAG_W;
    localparam int EXT_W = (QW > SAMPLE_W) ? QW : SAMPLE_W;
    localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        logic             sx;
        logic             sy;
        logic             zero;
        logic             clamp;
        logic [MAG_W-1:0] mag;
    } map_side_t;

    typedef struct packed {
        logic sx;
        logic sy;
        logic zero;
    } sign_side_t;

    logic [RADIUS_W-1:0] radius_reg;
    logic                en;

    // output beat register and skid
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    logic    sk_valid_reg;
    logic    sk_valid_next;
    result_t sk_data_reg;
    result_t sk_data_next;
    logic    up_valid;
    result_t up_data;
    logic    pop;
    logic    push;

    // stage 1: magnitudes and signs
    logic             v1_reg;
    logic [MAG_W-1:0] ax1_reg;
    logic [MAG_W-1:0] ax1_next;
    logic [MAG_W-1:0] ay1_reg;
    logic [MAG_W-1:0] ay1_next;
    logic             sx1_reg;
    logic             sy1_reg;

    // stage 2: squares
    logic             v2_reg;
    logic [SQ_W-1:0]  sqx2_reg;
    logic [SQ_W-1:0]  sqx2_next;
    logic [SQ_W-1:0]  sqy2_reg;
    logic [SQ_W-1:0]  sqy2_next;
    logic [RSQ_W-1:0] rsq2_reg;
    logic [RSQ_W-1:0] rsq2_next;
    logic [MAG_W-1:0] ax2_reg;
    logic [MAG_W-1:0] ay2_reg;
    logic             sx2_reg;
    logic             sy2_reg;

    // stage 3: squared magnitude and deadzone test
    logic            v3_reg;
    logic [SQ_W-1:0] s3_reg;
    logic [SQ_W-1:0] s3_next;
    axes_t           axes3_reg;
    axes_t           axes3_next;

    // square root
    logic             root_valid;
    logic [MAG_W-1:0] mag;
    axes_t            root_side;

    // stage 4: remap operands
    logic                   v4_reg;
    logic [ONE_W-1:0]       n4_reg;
    logic [ONE_W-1:0]       n4_next;
    logic [ONE_W-1:0]       d4_reg;
    logic [ONE_W-1:0]       d4_next;
    map_side_t              side4_reg;
    map_side_t              side4_next;
    logic [CMP_W-1:0]       diff4;
    logic [0:0][ONE_W-1:0]  map_rem;
    logic [0:0][FRAC_BITS-1:0] map_low;

    // remap divider
    logic                      map_valid;
    logic [0:0][FRAC_BITS-1:0] map_q;
    map_side_t                 map_side;

    // stage 5: scaled numerators
    logic             v5_reg;
    logic [ONE_W-1:0] mapped;
    logic [PW-1:0]    px5_reg;
    logic [PW-1:0]    px5_next;
    logic [PW-1:0]    py5_reg;
    logic [PW-1:0]    py5_next;
    logic [MAG_W-1:0] mag5_reg;
    sign_side_t       sign5_reg;
    sign_side_t       sign5_next;
    logic [1:0][MAG_W-1:0] axis_rem;
    logic [1:0][QW-1:0]    axis_low;

    // axis dividers
    logic               axis_valid;
    logic [1:0][QW-1:0] axis_q;
    sign_side_t         axis_side;

    assign cfg_ready   = 1'b1;
    assign en          = !sk_valid_reg;
    assign stick_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            radius_reg <= cfg_data;
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= stick_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= root_valid;
            v5_reg <= map_valid;
        end
    end

    always_comb
    begin
        ax1_next = stick.stick_x[SAMPLE_W-1] ? MAG_W'(-stick.stick_x) : MAG_W'(stick.stick_x);
        ay1_next = stick.stick_y[SAMPLE_W-1] ? MAG_W'(-stick.stick_y) : MAG_W'(stick.stick_y);
    end

    always_comb
    begin
        sqx2_next = SQ_W'(ax1_reg) * SQ_W'(ax1_reg);
        sqy2_next = SQ_W'(ay1_reg) * SQ_W'(ay1_reg);
        rsq2_next = RSQ_W'(radius_reg) * RSQ_W'(radius_reg);
    end

    always_comb
    begin
        s3_next         = sqx2_reg + sqy2_reg;
        axes3_next.ax   = ax2_reg;
        axes3_next.ay   = ay2_reg;
        axes3_next.sx   = sx2_reg;
        axes3_next.sy   = sy2_reg;
        axes3_next.zero = (s3_next < SQ_W'(rsq2_reg)) || (s3_next == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg   <= ax1_next;
            ay1_reg   <= ay1_next;
            sx1_reg   <= stick.stick_x[SAMPLE_W-1];
            sy1_reg   <= stick.stick_y[SAMPLE_W-1];
            sqx2_reg  <= sqx2_next;
            sqy2_reg  <= sqy2_next;
            rsq2_reg  <= rsq2_next;
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            sx2_reg   <= sx1_reg;
            sy2_reg   <= sy1_reg;
            s3_reg    <= s3_next;
            axes3_reg <= axes3_next;
        end
    end

    rdz_sqrt_pipe u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .sq_valid   (v3_reg),
        .sq         (s3_reg),
        .sq_side    (axes3_reg),
        .root_valid (root_valid),
        .root       (mag),
        .root_side  (root_side)
    );

    // remap: clamp when the radius reaches one or the magnitude reaches one
    always_comb
    begin
        diff4            = CMP_W'(mag) - CMP_W'(radius_reg);
        n4_next          = {1'b0, diff4[FRAC_BITS-1:0]};
        d4_next          = ONE - ONE_W'(radius_reg);
        side4_next.ax    = root_side.ax;
        side4_next.ay    = root_side.ay;
        side4_next.sx    = root_side.sx;
        side4_next.sy    = root_side.sy;
        side4_next.zero  = root_side.zero;
        side4_next.clamp = (CMP_W'(radius_reg) >= CMP_W'(ONE)) || (CMP_W'(mag) >= CMP_W'(ONE));
        side4_next.mag   = mag;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n4_reg    <= n4_next;
            d4_reg    <= d4_next;
            side4_reg <= side4_next;
        end
    end

    assign map_rem[0] = n4_reg;
    assign map_low[0] = '0;

    rdz_div_pipe #(
        .LANES  (1),
        .STEPS  (FRAC_BITS),
        .DEN_W  (ONE_W),
        .SIDE_W ($bits(map_side_t))
    ) u_map_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .num_valid  (v4_reg),
        .num_rem    (map_rem),
        .num_low    (map_low),
        .den        (d4_reg),
        .num_side   (side4_reg),
        .quot_valid (map_valid),
        .quot       (map_q),
        .quot_side  (map_side)
    );

    always_comb
    begin
        mapped          = map_side.clamp ? ONE : {1'b0, map_q[0]};
        px5_next        = PW'(map_side.ax) * PW'(mapped);
        py5_next        = PW'(map_side.ay) * PW'(mapped);
        sign5_next.sx   = map_side.sx;
        sign5_next.sy   = map_side.sy;
        sign5_next.zero = map_side.zero;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px5_reg   <= px5_next;
            py5_reg   <= py5_next;
            mag5_reg  <= map_side.mag;
            sign5_reg <= sign5_next;
        end
    end

    // lane 0 is x, lane 1 is y
    assign axis_rem[0] = px5_reg[PW-1:QW];
    assign axis_rem[1] = py5_reg[PW-1:QW];
    assign axis_low[0] = px5_reg[QW-1:0];
    assign axis_low[1] = py5_reg[QW-1:0];

    rdz_div_pipe #(
        .LANES  (2),
        .STEPS  (QW),
        .DEN_W  (MAG_W),
        .SIDE_W ($bits(sign_side_t))
    ) u_axis_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .num_valid  (v5_reg),
        .num_rem    (axis_rem),
        .num_low    (axis_low),
        .den        (mag5_reg),
        .num_side   (sign5_reg),
        .quot_valid (axis_valid),
        .quot       (axis_q),
        .quot_side  (axis_side)
    );

    // sign restore, zero forcing in the deadzone and wrap to the field width
    always_comb
    begin
        logic [EXT_W-1:0] ext_x;
        logic [EXT_W-1:0] ext_y;
        logic [EXT_W-1:0] sgn_x;
        logic [EXT_W-1:0] sgn_y;
        ext_x    = EXT_W'(axis_q[0]);
        ext_y    = EXT_W'(axis_q[1]);
        sgn_x    = axis_side.sx ? (-ext_x) : ext_x;
        sgn_y    = axis_side.sy ? (-ext_y) : ext_y;
        up_valid = axis_valid;
        up_data.out_x = axis_side.zero ? '0 : sgn_x[SAMPLE_W-1:0];
        up_data.out_y = axis_side.zero ? '0 : sgn_y[SAMPLE_W-1:0];
    end

    always_comb
    begin
        pop            = out_valid_reg && result_ready;
        push           = up_valid && en;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        sk_valid_next  = sk_valid_reg;
        sk_data_next   = sk_data_reg;
        if (sk_valid_reg)
        begin
            if (pop)
            begin
                out_data_next = sk_data_reg;
                sk_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = up_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                sk_data_next  = up_data;
                sk_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sk_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sk_valid_reg  <= sk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        sk_data_reg  <= sk_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    `RDZ_ASSERT_IMP(a_skid_has_out, sk_valid_reg, out_valid_reg)
    `RDZ_ASSERT_NEXT(a_skid_holds, sk_valid_reg && !result_ready, sk_valid_reg && $stable(sk_data_reg))
    `RDZ_ASSERT_IMP(a_skid_fill_cause, $rose(sk_valid_reg), $past(out_valid_reg && !result_ready))
    `RDZ_ASSERT_NEXT(a_cfg_write, cfg_valid && cfg_ready, radius_reg == $past(cfg_data))

endmodule

// ===== test/radial_deadzone_rescale_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radial_deadzone_rescale_unit_test
// self-checking bench for the radial deadzone rescale unit: a directed table
// of edge samples, then random samples over several deadzone radii, each
// result compared against its table value or an in-bench integer rescale
// predictor while both handshakes idle and stall at random
// ----------------------------------------------------------------------------
module radial_deadzone_rescale_unit_test;

    import rdz_pkg::*;

    localparam int              FRAC_BITS   = 14;
    localparam longint unsigned ONE_Q       = 64'd1 << FRAC_BITS;
    localparam int              RANDOM_PER  = 100;
    localparam int              PHASES      = 8;
    localparam int              CYCLE_LIMIT = 400000;
    localparam int              NUM_VECTORS = 22;

    typedef struct packed {
        logic [RADIUS_W-1:0]        radius;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic                       known;
        logic signed [SAMPLE_W-1:0] ex;
        logic signed [SAMPLE_W-1:0] ey;
    } vector_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                stick_valid;
    logic                stick_ready;
    stick_t              stick;
    logic                result_valid;
    logic                result_ready = 1'b0;
    result_t             result;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [RADIUS_W-1:0] cfg_data;

    result_t             pending_results [$];
    logic [RADIUS_W-1:0] radius_now;
    bit                  quiet;
    int                  stall_left = 0;
    int                  cycles = 0;
    int                  mismatches;
    int                  beats_sent;
    int                  beats_checked;
    int                  directed_count;
    int                  random_count;
    int                  settings_count;

    vector_t vectors [NUM_VECTORS] = '{
        '{14'd2458,  16'sd0,      16'sd0,      1'b1, 16'sd0,      16'sd0},
        '{14'd2458,  16'sd16384,  16'sd0,      1'b1, 16'sd16384,  16'sd0},
        '{14'd2458, -16'sd16384,  16'sd0,      1'b1, -16'sd16384, 16'sd0},
        '{14'd2458,  16'sd0,      16'sd16384,  1'b1, 16'sd0,      16'sd16384},
        '{14'd2458,  16'sd0,     -16'sd16384,  1'b1, 16'sd0,     -16'sd16384},
        '{14'd2458,  16'sd2457,   16'sd0,      1'b1, 16'sd0,      16'sd0},
        '{14'd2458,  16'sd0,     -16'sd2458,   1'b1, 16'sd0,      16'sd0},
        '{14'd2458, -16'sd1,      16'sd1,      1'b1, 16'sd0,      16'sd0},
        '{14'd2458,  16'sd32767,  16'sd0,      1'b1, 16'sd16384,  16'sd0},
        '{14'd2458,  16'sh8000,   16'sh8000,   1'b0, 16'sd0,      16'sd0},
        '{14'd2458,  16'sh8000,   16'sd32767,  1'b0, 16'sd0,      16'sd0},
        '{14'd2458,  16'sd16384,  16'sd16384,  1'b0, 16'sd0,      16'sd0},
        '{14'd2458,  16'sd1000,  -16'sd2000,   1'b0, 16'sd0,      16'sd0},
        '{14'd0,     16'sd0,      16'sd0,      1'b1, 16'sd0,      16'sd0},
        '{14'd0,     16'sd1,      16'sd0,      1'b1, 16'sd1,      16'sd0},
        '{14'd0,    -16'sd3,      16'sd4,      1'b1, -16'sd3,     16'sd4},
        '{14'd0,     16'sh5555,   16'shAAAA,   1'b0, 16'sd0,      16'sd0},
        '{14'd0,     16'sd16384,  16'sd16384,  1'b0, 16'sd0,      16'sd0},
        '{14'd16383, 16'sd16384,  16'sd0,      1'b1, 16'sd16384,  16'sd0},
        '{14'd16383, 16'sd16383,  16'sd0,      1'b1, 16'sd0,      16'sd0},
        '{14'd16383, 16'sd0,     -16'sd16382,  1'b1, 16'sd0,      16'sd0},
        '{14'd16383, 16'sd12000,  16'sd12000,  1'b0, 16'sd0,      16'sd0}
    };

    radial_deadzone_rescale_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .stick_valid (stick_valid),
        .stick_ready (stick_ready),
        .stick       (stick),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic longint unsigned isqrt(longint unsigned s);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > s)
            probe >>= 2;
        while (probe != 0)
        begin
            if (s >= root + probe)
            begin
                s    = s - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic logic [SAMPLE_W-1:0] scale_axis(longint v, longint unsigned mapped,
                                                        longint unsigned mag);
        longint unsigned a;
        longint unsigned q;
        a = (v < 0) ? longint'(-v) : longint'(v);
        q = (a * mapped) / mag;
        if (v < 0)
            q = 64'd0 - q;
        return q[SAMPLE_W-1:0];
    endfunction

    function automatic result_t rescale_stick(stick_t s, logic [RADIUS_W-1:0] radius);
        result_t         r;
        longint          x;
        longint          y;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned rad;
        longint unsigned mag_sq;
        longint unsigned mag;
        longint unsigned mapped;
        x      = s.stick_x;
        y      = s.stick_y;
        ax     = (x < 0) ? longint'(-x) : longint'(x);
        ay     = (y < 0) ? longint'(-y) : longint'(y);
        rad    = radius;
        mag_sq = ax * ax + ay * ay;
        r      = '0;
        if (mag_sq < rad * rad)
            return r;
        mag = isqrt(mag_sq);
        if (mag == 0)
            return r;
        if (rad >= ONE_Q)
            mapped = ONE_Q;
        else
        begin
            mapped = ((mag - rad) * ONE_Q) / (ONE_Q - rad);
            if (mapped > ONE_Q)
                mapped = ONE_Q;
        end
        r.out_x = scale_axis(x, mapped, mag);
        r.out_y = scale_axis(y, mapped, mag);
        return r;
    endfunction

    function automatic int extreme_value();
        case ($urandom_range(0, 4))
            0:       return -32768;
            1:       return -16384;
            2:       return 0;
            3:       return 16384;
            default: return 32767;
        endcase
    endfunction

    // mostly in-range or near the deadzone edge, some full-width noise
    function automatic stick_t random_stick(logic [RADIUS_W-1:0] radius);
        stick_t s;
        int     x;
        int     y;
        int     t;
        int     pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
        begin
            x = int'($urandom_range(0, 32768)) - 16384;
            y = int'($urandom_range(0, 32768)) - 16384;
        end
        else if (pick < 5)
        begin
            x = int'($urandom);
            y = int'($urandom);
        end
        else if (pick < 8)
        begin
            x = int'(radius) + int'($urandom_range(0, 40)) - 20;
            if (x < 0)
                x = 0;
            y = $urandom_range(0, 6);
            if ($urandom_range(0, 1))
                x = -x;
            if ($urandom_range(0, 1))
                y = -y;
            if ($urandom_range(0, 1))
            begin
                t = x;
                x = y;
                y = t;
            end
        end
        else if (pick == 8)
        begin
            x = extreme_value();
            y = extreme_value();
        end
        else
        begin
            x = int'($urandom_range(0, 64)) - 32;
            y = int'($urandom_range(0, 64)) - 32;
        end
        s.stick_x = x[SAMPLE_W-1:0];
        s.stick_y = y[SAMPLE_W-1:0];
        return s;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_stick(stick_t s, logic known, result_t typed);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            stick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stick       <= s;
        stick_valid <= 1'b1;
        do @(negedge clk); while (!stick_ready);
        @(posedge clk);
        pending_results.push_back(known ? typed : rescale_stick(s, radius_now));
        beats_sent++;
    endtask

    task automatic load_radius(logic [RADIUS_W-1:0] r);
        stick_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_data  <= r;
        cfg_valid <= 1'b1;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        radius_now = r;
        settings_count++;
    endtask

    task automatic check_field(string name, logic signed [SAMPLE_W-1:0] want,
                               logic signed [SAMPLE_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("beat %0d %s: expected %0d, got %0d", beats_checked, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            result_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0)
                stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                           : $urandom_range(8, 40);
        end
    end

    // result beat is taken at the next rising edge, payload is stable here
    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: out_x %0d out_y %0d",
                             result.out_x, result.out_y);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("out_x", want.out_x, result.out_x);
                check_field("out_y", want.out_y, result.out_y);
            end
            beats_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles, pending_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [RADIUS_W-1:0] r;
        rst_n          = 1'b0;
        stick_valid    = 1'b0;
        stick          = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        quiet          = 1'b0;
        mismatches     = 0;
        beats_sent     = 0;
        beats_checked  = 0;
        directed_count = 0;
        random_count   = 0;
        settings_count = 0;
        radius_now     = RADIUS_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[i])
        begin
            if (vectors[i].radius != radius_now)
                load_radius(vectors[i].radius);
            send_stick('{stick_x: vectors[i].x, stick_y: vectors[i].y}, vectors[i].known,
                       '{out_x: vectors[i].ex, out_y: vectors[i].ey});
            directed_count++;
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       r = 14'd1000;
                1:       r = 14'd0;
                2:       r = 14'd16383;
                3, 5:    r = RADIUS_W'($urandom_range(0, 16383));
                4:       r = RADIUS_RESET;
                6:       r = 14'd1;
                default: r = 14'd8191;
            endcase
            load_radius(r);
            quiet = (ph == 3 || ph == 6);
            repeat (RANDOM_PER)
            begin
                send_stick(random_stick(radius_now), 1'b0, '0);
                random_count++;
            end
        end
        quiet = 1'b0;

        stick_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);

        $display("sent %0d directed and %0d random samples across %0d radius writes",
                 directed_count, random_count, settings_count);
        $display("checked %0d result beats, %0d mismatches", beats_checked, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
